/* rtl/core/pfe_pkg.sv */
`timescale 1ns / 1ps

package pfe_pkg;

  // Palette size default
  localparam int DEF_PALETTE_ENTRIES = 256;

  // Field widths
  localparam int IDX_W   = 8;
  localparam int COLOR_W = 15;
  localparam int FRAME_W = 12;
  localparam int CH_W    = 5;
  localparam int FRAC_W  = 8;
  localparam int NUM_CH  = 3;

  // 5.8 level and signed step per channel
  localparam int LEVEL_W = CH_W + FRAC_W;   // 13
  localparam int QUOT_W  = CH_W + FRAC_W;   // 13
  localparam int STEP_W  = QUOT_W + 1;      // 14
  localparam int SUM_W   = STEP_W + 1;      // 15

  localparam int GREEN_POS = 5;
  localparam int BLUE_POS  = 10;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX = {LEVEL_W{1'b1}};

  // Configuration
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_FADE_DIRECTION = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT    = 1'b1;
  localparam logic [FRAME_W-1:0]   FRAME_COUNT_RESET  = 12'd16;

  // Actions
  localparam logic ACT_LOAD    = 1'b0;
  localparam logic ACT_ADVANCE = 1'b1;

  // Divider status back to the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } pfe_div_stat_t;

  // Pick one 5-bit channel out of an RGB555 word
  function automatic logic [CH_W-1:0] chan_of(input logic [COLOR_W-1:0] color,
                                              input logic [1:0] sel);
    logic [CH_W-1:0] ch;
    unique case (sel)
      2'd1:    ch = color[GREEN_POS +: CH_W];
      2'd2:    ch = color[BLUE_POS +: CH_W];
      default: ch = color[0 +: CH_W];
    endcase
    return ch;
  endfunction

endpackage

/* rtl/core/palette_fade_engine.sv */
`timescale 1ns / 1ps

// Channel  Handshake            Word
// in       in_valid / in_ready  action, entry_index, color_in
// out      out_valid/out_ready  entry_out, color_out
// cfg      cfg_valid/cfg_ready  cfg_index, cfg_data (0 fade_direction, 1 frame_count)
//
// A load runs three divisions by frame_count (each a start, 13 restoring steps
// and a result) on one shared divider, then one write to the step and level
// memories, then returns to idle.
// An advance runs a memory read, a read wait, then a saturating add with level
// write-back, then returns to idle.
// in_ready is high only between items; cfg_ready is always high.
// A result waiting in the output register stalls only a following advance.
// Reset is synchronous; the step and level memories are not cleared.

module palette_fade_engine
  import pfe_pkg::*;
#(
  parameter int PALETTE_ENTRIES = DEF_PALETTE_ENTRIES
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 action,
  input  logic [IDX_W-1:0]     entry_index,
  input  logic [COLOR_W-1:0]   color_in,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [IDX_W-1:0]     entry_out,
  output logic [COLOR_W-1:0]   color_out,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [FRAME_W-1:0]   cfg_data
);

  localparam int AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam int IW = (AW > IDX_W) ? AW : IDX_W;
  localparam int STEP_ROW_W  = NUM_CH * STEP_W;
  localparam int LEVEL_ROW_W = NUM_CH * LEVEL_W;

  // Sequencer states
  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_DIV_START = 3'd1;
  localparam logic [2:0] S_DIV_WAIT  = 3'd2;
  localparam logic [2:0] S_LOAD_WR   = 3'd3;
  localparam logic [2:0] S_ADV_RD    = 3'd4;
  localparam logic [2:0] S_ADV_WAIT  = 3'd5;
  localparam logic [2:0] S_ADV_UPD   = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  // Configuration registers
  logic               fade_direction;
  logic [FRAME_W-1:0] frame_count;

  // Latched item
  logic               dir_r;
  logic [FRAME_W-1:0] div_r;
  logic [IDX_W-1:0]   idx_r;
  logic [COLOR_W-1:0] color_r;
  logic [1:0]         chan;
  logic [QUOT_W-1:0]  quot_r [NUM_CH];

  logic in_fire;
  logic in_range;
  logic out_free;

  logic [IW-1:0] idx_wide;
  logic [AW-1:0] addr;

  // Divider hookup
  logic               div_start;
  logic [QUOT_W-1:0]  div_quot;
  pfe_div_stat_t      div_stat;

  // Memory ports
  logic                   step_we;
  logic                   level_we;
  logic                   mem_re;
  logic [STEP_ROW_W-1:0]  step_wdata;
  logic [LEVEL_ROW_W-1:0] level_wdata;
  logic [LEVEL_ROW_W-1:0] level_load;
  logic [STEP_ROW_W-1:0]  step_rdata;
  logic [LEVEL_ROW_W-1:0] level_rdata;
  logic [LEVEL_ROW_W-1:0] level_adv;
  logic [COLOR_W-1:0]     color_adv;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign in_range  = (int'(entry_index) < PALETTE_ENTRIES);
  assign out_free  = !out_valid || out_ready;

  assign idx_wide  = IW'(idx_r);
  assign addr      = idx_wide[AW-1:0];

  // Config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      fade_direction <= 1'b0;
      frame_count    <= FRAME_COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FADE_DIRECTION: fade_direction <= cfg_data[0];
        REG_FRAME_COUNT:    frame_count    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_fire && in_range) begin
          state_next = (action == ACT_ADVANCE) ? S_ADV_RD : S_DIV_START;
        end
      end
      S_DIV_START: state_next = S_DIV_WAIT;
      S_DIV_WAIT: begin
        if (div_stat.done) begin
          state_next = (chan == 2'd2) ? S_LOAD_WR : S_DIV_START;
        end
      end
      S_LOAD_WR:  state_next = S_IDLE;
      S_ADV_RD:   state_next = S_ADV_WAIT;
      S_ADV_WAIT: state_next = S_ADV_UPD;
      S_ADV_UPD: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default:    state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Item capture and channel counter
  always_ff @(posedge clk) begin
    if (in_fire) begin
      idx_r   <= entry_index;
      color_r <= color_in;
      dir_r   <= fade_direction;
      div_r   <= (frame_count == '0) ? FRAME_W'(1) : frame_count;
      chan    <= 2'd0;
    end else if (state == S_DIV_WAIT && div_stat.done) begin
      quot_r[chan] <= div_quot;
      chan         <= chan + 2'd1;
    end
  end

  assign div_start = (state == S_DIV_START);

  pfe_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({chan_of(color_r, chan), FRAC_W'(0)}),
    .divisor  (div_r),
    .quotient (div_quot),
    .stat     (div_stat)
  );

  // Load row: signed steps and starting levels
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      if (dir_r) begin
        step_wdata[c*STEP_W +: STEP_W] = STEP_W'(0) - {1'b0, quot_r[c]};
        level_load[c*LEVEL_W +: LEVEL_W] = {chan_of(color_r, 2'(c)), FRAC_W'(0)};
      end else begin
        step_wdata[c*STEP_W +: STEP_W] = {1'b0, quot_r[c]};
        level_load[c*LEVEL_W +: LEVEL_W] = '0;
      end
    end
  end

  // Advance: per-channel saturating add, independent lanes
  always_comb begin
    logic signed [SUM_W-1:0] sum;
    for (int c = 0; c < NUM_CH; c++) begin
      sum = $signed({2'b00, level_rdata[c*LEVEL_W +: LEVEL_W]})
          + $signed({step_rdata[c*STEP_W + STEP_W - 1], step_rdata[c*STEP_W +: STEP_W]});
      if (sum < 0) begin
        level_adv[c*LEVEL_W +: LEVEL_W] = '0;
      end else if (sum > $signed({2'b00, LEVEL_MAX})) begin
        level_adv[c*LEVEL_W +: LEVEL_W] = LEVEL_MAX;
      end else begin
        level_adv[c*LEVEL_W +: LEVEL_W] = sum[LEVEL_W-1:0];
      end
      color_adv[c*CH_W +: CH_W] = level_adv[c*LEVEL_W + FRAC_W +: CH_W];
    end
  end

  assign mem_re      = (state == S_ADV_RD);
  assign step_we     = (state == S_LOAD_WR);
  assign level_we    = (state == S_LOAD_WR) || (state == S_ADV_UPD && out_free);
  assign level_wdata = (state == S_LOAD_WR) ? level_load : level_adv;

  pfe_ram #(.WIDTH(STEP_ROW_W), .DEPTH(PALETTE_ENTRIES)) u_step_ram (
    .clk   (clk),
    .we    (step_we),
    .waddr (addr),
    .wdata (step_wdata),
    .re    (mem_re),
    .raddr (addr),
    .rdata (step_rdata)
  );

  pfe_ram #(.WIDTH(LEVEL_ROW_W), .DEPTH(PALETTE_ENTRIES)) u_level_ram (
    .clk   (clk),
    .we    (level_we),
    .waddr (addr),
    .wdata (level_wdata),
    .re    (mem_re),
    .raddr (addr),
    .rdata (level_rdata)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_ADV_UPD && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_ADV_UPD && out_free) begin
      entry_out <= idx_r;
      color_out <= color_adv;
    end
  end

  // Checks
  a_idle_div: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !div_stat.busy)
    else $error("divider busy while accepting words");

  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_ADV_UPD)
    else $error("result raised outside the advance update");

  a_load_quiet: assert property (@(posedge clk) disable iff (rst)
    (in_fire && action == ACT_LOAD) |=> !$rose(out_valid))
    else $error("load produced a result");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> state == S_DIV_WAIT)
    else $error("divider finished outside a wait state");

endmodule

/* rtl/core/pfe_ram.sv */
`timescale 1ns / 1ps

module pfe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/pfe_div.sv */
`timescale 1ns / 1ps

module pfe_div
  import pfe_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [QUOT_W-1:0]  dividend,
  input  logic [FRAME_W-1:0] divisor,
  output logic [QUOT_W-1:0]  quotient,
  output pfe_div_stat_t      stat
);

  localparam int CNT_W = $clog2(QUOT_W + 1);

  logic [CNT_W-1:0]   cnt;
  logic [FRAME_W-1:0] rem;
  logic [FRAME_W-1:0] dvs;
  logic [QUOT_W-1:0]  quot;
  logic               done;

  logic [FRAME_W:0]   rem_sh;
  logic [FRAME_W+1:0] diff;

  // Restoring step: shift in next dividend bit, trial subtract
  always_comb begin
    rem_sh = {rem, quot[QUOT_W-1]};
    diff   = {1'b0, rem_sh} - {2'b00, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CNT_W'(QUOT_W);
      end else if (cnt != '0) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: quotient register starts as the dividend, bits shift out
  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem  <= '0;
      dvs  <= divisor;
    end else if (cnt != '0) begin
      if (!diff[FRAME_W+1]) begin
        rem <= diff[FRAME_W-1:0];
      end else begin
        rem <= rem_sh[FRAME_W-1:0];
      end
      quot <= {quot[QUOT_W-2:0], ~diff[FRAME_W+1]};
    end
  end

  assign quotient  = quot;
  assign stat.busy = (cnt != '0);
  assign stat.done = done;

endmodule

/* tb/palette_fade_engine_test.sv */
`timescale 1ns / 1ps

module palette_fade_engine_test
  import pfe_pkg::*;
();

  localparam int PALETTE_SIZE  = DEF_PALETTE_ENTRIES;
  // a load gives no word back
  localparam int SETTLE_CYCLES = 64;

  typedef struct packed {
    logic [IDX_W-1:0]   entry;
    logic [COLOR_W-1:0] color;
  } fade_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 action = ACT_LOAD;
  logic [IDX_W-1:0]     entry_index = '0;
  logic [COLOR_W-1:0]   color_in = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [IDX_W-1:0]     entry_out;
  logic [COLOR_W-1:0]   color_out;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_FADE_DIRECTION;
  logic [FRAME_W-1:0]   cfg_data = '0;

  // Mirror of the fade state and registers
  logic signed [STEP_W-1:0] step_mem [PALETTE_SIZE][NUM_CH];
  logic [LEVEL_W-1:0]       level_mem [PALETTE_SIZE][NUM_CH];
  bit                       loaded [PALETTE_SIZE];
  logic [IDX_W-1:0]         loaded_list [$];
  logic                     dim_mode = 1'b0;
  logic [FRAME_W-1:0]       frame_len = FRAME_COUNT_RESET;

  fade_result_t pending_colors [$];
  fade_result_t want;
  int           error_count = 0;
  int           send_idle_pct = 0;
  int           stall_pct = 0;

  palette_fade_engine DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .action(action),
    .entry_index(entry_index),
    .color_in(color_in),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .entry_out(entry_out),
    .color_out(color_out),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Receiver back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Update the mirror for one accepted word; an advance queues its color
  function automatic void track_fade(input logic act, input logic [IDX_W-1:0] idx,
                                     input logic [COLOR_W-1:0] color);
    logic [LEVEL_W-1:0]       base;
    logic [QUOT_W-1:0]        quot;
    logic [FRAME_W-1:0]       divisor;
    logic signed [SUM_W-1:0]  sum;
    logic [COLOR_W-1:0]       packed_color;
    fade_result_t             res;
    // zero frames behaves as one
    divisor = (frame_len == '0) ? FRAME_W'(1) : frame_len;
    packed_color = '0;
    if (act == ACT_LOAD) begin
      // channel c sits at bit c*5: red, green, blue
      for (int c = 0; c < NUM_CH; c++) begin
        base = {color[c*CH_W +: CH_W], {FRAC_W{1'b0}}};
        quot = base / divisor;
        step_mem[idx][c] = dim_mode ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
        level_mem[idx][c] = dim_mode ? base : '0;
      end
      if (!loaded[idx]) begin
        loaded[idx] = 1'b1;
        loaded_list.push_back(idx);
      end
    end else begin
      // saturating add, final color holds past the end of the fade
      for (int c = 0; c < NUM_CH; c++) begin
        sum = $signed({2'b00, level_mem[idx][c]}) + step_mem[idx][c];
        if (sum < 0)
          level_mem[idx][c] = '0;
        else if (sum > $signed({2'b00, LEVEL_MAX}))
          level_mem[idx][c] = LEVEL_MAX;
        else
          level_mem[idx][c] = sum[LEVEL_W-1:0];
        packed_color[c*CH_W +: CH_W] = level_mem[idx][c][LEVEL_W-1 -: CH_W];
      end
      res.entry = idx;
      res.color = packed_color;
      pending_colors.push_back(res);
    end
  endfunction

  // Present one word, keep it steady until taken
  task automatic send_word(input logic act, input logic [IDX_W-1:0] idx,
                           input logic [COLOR_W-1:0] color);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid    <= 1'b1;
    action      <= act;
    entry_index <= idx;
    color_in    <= color;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    track_fade(act, idx, color);
  endtask

  // Hold off input until every color is back and the block is idle
  task automatic settle_block();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_colors.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [FRAME_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_FADE_DIRECTION)
      dim_mode = value[0];
    else
      frame_len = value;
    @(posedge clk);
  endtask

  // Result check against the oldest queued color
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_colors.size() == 0) begin
        $display("%0t: unexpected word entry %0d color %h", $time, entry_out, color_out);
        error_count++;
      end else begin
        want = pending_colors.pop_front();
        if (entry_out !== want.entry) begin
          $display("%0t: entry_out expected %0d got %0d", $time, want.entry, entry_out);
          error_count++;
        end
        if (color_out !== want.color) begin
          $display("%0t: color_out entry %0d expected %h got %h",
                   $time, want.entry, want.color, color_out);
          error_count++;
        end
      end
    end
  end

  // Reset values, full white, black and each pure channel
  task automatic test_basic_colors();
    send_word(ACT_LOAD, 8'd0, 15'h7FFF);
    send_word(ACT_LOAD, 8'd255, 15'h0000);
    send_word(ACT_LOAD, 8'h55, 15'h001F);
    send_word(ACT_LOAD, 8'hAA, 15'h03E0);
    send_word(ACT_LOAD, 8'h0F, 15'h7C00);
    send_word(ACT_ADVANCE, 8'd0, 15'h0000);
    send_word(ACT_ADVANCE, 8'd255, 15'h7FFF);
    send_word(ACT_ADVANCE, 8'h55, 15'h2AAA);
    send_word(ACT_ADVANCE, 8'hAA, 15'h5555);
    send_word(ACT_ADVANCE, 8'h0F, 15'h0000);
    settle_block();
  endtask

  // One-frame fade in reaches the target, then saturates and holds
  task automatic test_single_frame();
    write_reg(REG_FADE_DIRECTION, '0);
    write_reg(REG_FRAME_COUNT, 12'd1);
    send_word(ACT_LOAD, 8'd1, 15'h7FFF);
    send_word(ACT_ADVANCE, 8'd1, 15'h0000);
    send_word(ACT_ADVANCE, 8'd1, 15'h0000);
    settle_block();
  endtask

  // Longest fade to black: step of minus one per frame
  task automatic test_long_dimming();
    write_reg(REG_FADE_DIRECTION, 12'd1);
    write_reg(REG_FRAME_COUNT, 12'd4095);
    send_word(ACT_LOAD, 8'd2, 15'h7FFF);
    send_word(ACT_ADVANCE, 8'd2, 15'h0000);
    send_word(ACT_ADVANCE, 8'd2, 15'h0000);
    settle_block();
  endtask

  // Zero frames acts as one; fade to black clamps at black
  task automatic test_zero_frame_count();
    write_reg(REG_FRAME_COUNT, 12'd0);
    send_word(ACT_LOAD, 8'd3, 15'h5A5A);
    send_word(ACT_ADVANCE, 8'd3, 15'h0000);
    send_word(ACT_ADVANCE, 8'd3, 15'h0000);
    settle_block();
  endtask

  // Mostly load-then-advance runs, plus stray loads and advances
  task automatic run_random_phase(input int count);
    int               sent;
    int               pick;
    int               steps;
    bit               paused;
    logic [IDX_W-1:0] idx;
    sent = 0;
    paused = 1'b0;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        idx = IDX_W'($urandom_range(PALETTE_SIZE - 1));
        send_word(ACT_LOAD, idx, COLOR_W'($urandom_range(32767)));
        steps = $urandom_range(1, 12);
        repeat (steps) send_word(ACT_ADVANCE, idx, COLOR_W'($urandom_range(32767)));
        sent += steps + 1;
      end else if (pick < 88 && loaded_list.size() != 0) begin
        idx = loaded_list[$urandom_range(loaded_list.size() - 1)];
        send_word(ACT_ADVANCE, idx, COLOR_W'($urandom_range(32767)));
        sent++;
      end else begin
        send_word(ACT_LOAD, IDX_W'($urandom_range(PALETTE_SIZE - 1)),
                  COLOR_W'($urandom_range(32767)));
        sent++;
      end
      // drain the pipe once mid-phase
      if (!paused && sent >= count / 2) begin
        settle_block();
        paused = 1'b1;
      end
    end
    settle_block();
  endtask

  task automatic test_random_no_idle();
    send_idle_pct = 0;
    stall_pct = 0;
    write_reg(REG_FADE_DIRECTION, '0);
    write_reg(REG_FRAME_COUNT, 12'd3);
    run_random_phase(360);
  endtask

  task automatic test_random_sender_idle();
    send_idle_pct = 76;
    stall_pct = 0;
    write_reg(REG_FADE_DIRECTION, 12'd1);
    write_reg(REG_FRAME_COUNT, FRAME_W'($urandom_range(2, 64)));
    run_random_phase(360);
  endtask

  task automatic test_random_receiver_stall();
    send_idle_pct = 0;
    stall_pct = 76;
    write_reg(REG_FADE_DIRECTION, '0);
    write_reg(REG_FRAME_COUNT, FRAME_W'($urandom_range(5, 40)));
    run_random_phase(360);
  endtask

  task automatic test_random_both_idle();
    send_idle_pct = 19;
    stall_pct = 19;
    write_reg(REG_FADE_DIRECTION, 12'd1);
    write_reg(REG_FRAME_COUNT, 12'd4095);
    run_random_phase(180);
    write_reg(REG_FADE_DIRECTION, '0);
    write_reg(REG_FRAME_COUNT, 12'd1);
    run_random_phase(180);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_basic_colors();
    test_single_frame();
    test_long_dimming();
    test_zero_frame_count();
    test_random_no_idle();
    test_random_sender_idle();
    test_random_receiver_stall();
    test_random_both_idle();
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

/* palette_fade_engine.f */
rtl/core/pfe_pkg.sv
rtl/core/pfe_ram.sv
rtl/core/pfe_div.sv
rtl/core/palette_fade_engine.sv
tb/palette_fade_engine_test.sv
